// ----- sv/cvr_pkg.sv -----
// ----------------------------------------------------------------------------
// cvr_pkg: types, constants and arithmetic helpers
// Signed Q16.16 helpers and the pipeline record of the velocity resolver.
// ----------------------------------------------------------------------------
package cvr_pkg;

  localparam int unsigned DIV_W  = 48;
  localparam int unsigned ST_DIV = 10;
  localparam int unsigned ST_J   = ST_DIV + DIV_W + 1;
  localparam int unsigned NSTG   = ST_J + 5;
  localparam logic [31:0] EPS_RST = 32'd1;

  typedef logic [2:0][31:0] vec_t;
  typedef logic [2:0][64:0] prod3_t;

  typedef struct packed {
    vec_t        vs;
    vec_t        vt;
    vec_t        n;
    vec_t        dv;
    vec_t        r;
    vec_t        t;
    vec_t        so;
    prod3_t      pr;
    prod3_t      pm;
    prod3_t      pc;
    logic [64:0] sc;
    logic [64:0] pa;
    logic [64:0] pb;
    logic [31:0] ms;
    logic [31:0] mt;
    logic [32:0] total;
    logic [16:0] cor;
    logic        at_rest;
    logic        big;
    logic        ms_big;
    logic        mt_big;
    logic        neg;
    logic [31:0] d2;
    logic [31:0] dm;
    logic [31:0] dr;
    logic [31:0] dd2;
    logic [31:0] b;
    logic [31:0] dmv;
    logic [31:0] num;
    logic [31:0] j;
    logic [31:0] ks;
    logic [31:0] kt;
    logic [32:0] rem;
    logic [DIV_W-1:0] quo;
  } pipe_t;

  function automatic logic [31:0] sat32(input logic signed [65:0] x);
    if (!x[65] && (|x[64:31])) return 32'h7FFF_FFFF;
    if (x[65] && !(&x[64:31])) return 32'h8000_0000;
    return x[31:0];
  endfunction

  function automatic logic signed [65:0] sx(input logic [31:0] a);
    return {{34{a[31]}}, a};
  endfunction

  function automatic logic signed [32:0] sx33(input logic [31:0] a);
    return {a[31], a};
  endfunction

  function automatic logic signed [64:0] smul(input logic signed [31:0] a,
                                              input logic signed [32:0] b);
    logic signed [64:0] ae;
    logic signed [64:0] be;
    ae = 65'(a);
    be = 65'(b);
    return ae * be;
  endfunction

  function automatic logic [31:0] mulq(input logic [64:0] p);
    logic signed [65:0] t;
    t = $signed({p[64], p}) >>> 16;
    return sat32(t);
  endfunction

  function automatic logic [31:0] dot3(input prod3_t p);
    logic signed [65:0] s;
    s = ($signed({p[0][64], p[0]}) >>> 16) + ($signed({p[1][64], p[1]}) >>> 16)
      + ($signed({p[2][64], p[2]}) >>> 16);
    return sat32(s);
  endfunction

  function automatic logic [31:0] dbl(input logic [31:0] a);
    return sat32(sx(a) <<< 1);
  endfunction

  function automatic logic [31:0] nsat(input logic [31:0] a);
    return sat32(-sx(a));
  endfunction

  function automatic logic [31:0] abs32(input logic [31:0] a);
    return a[31] ? (~a + 32'd1) : a;
  endfunction

endpackage

// ----- sv/cvr_if.sv -----
// ----------------------------------------------------------------------------
// cvr_if: channel interfaces
// Contact request, resolved velocity and epsilon write channels.
// ----------------------------------------------------------------------------
interface cvr_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] src_vel_x;
  logic signed [31:0] src_vel_y;
  logic signed [31:0] src_vel_z;
  logic signed [31:0] tgt_vel_x;
  logic signed [31:0] tgt_vel_y;
  logic signed [31:0] tgt_vel_z;
  logic signed [31:0] normal_x;
  logic signed [31:0] normal_y;
  logic signed [31:0] normal_z;
  logic        [31:0] src_mass;
  logic        [31:0] tgt_mass;
  logic        [33:0] restitution_pair;
  modport source (output valid, src_vel_x, src_vel_y, src_vel_z, tgt_vel_x, tgt_vel_y,
                  tgt_vel_z, normal_x, normal_y, normal_z, src_mass, tgt_mass,
                  restitution_pair, input ready);
  modport sink (input valid, src_vel_x, src_vel_y, src_vel_z, tgt_vel_x, tgt_vel_y,
                tgt_vel_z, normal_x, normal_y, normal_z, src_mass, tgt_mass,
                restitution_pair, output ready);
endinterface

interface cvr_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] src_out_x;
  logic signed [31:0] src_out_y;
  logic signed [31:0] src_out_z;
  logic signed [31:0] tgt_out_x;
  logic signed [31:0] tgt_out_y;
  logic signed [31:0] tgt_out_z;
  modport source (output valid, src_out_x, src_out_y, src_out_z, tgt_out_x, tgt_out_y,
                  tgt_out_z, input ready);
  modport sink (input valid, src_out_x, src_out_y, src_out_z, tgt_out_x, tgt_out_y,
                tgt_out_z, output ready);
endinterface

interface cvr_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] epsilon;
  modport source (output valid, epsilon, input ready);
  modport sink (input valid, epsilon, output ready);
endinterface

// ----- sv/collision_velocity_resolver.sv -----
// ----------------------------------------------------------------------------
// collision_velocity_resolver: two-body contact velocity resolution
// Restitution impulse along the contact normal, Q16.16, saturating.
// ----------------------------------------------------------------------------
//  channel | dir | payload                              | request taken when
//  in_if   | in  | velocities, normal, masses, e pair   | valid & ready
//  out_if  | out | resolved source and target velocity  | valid & ready
//  cfg_if  | in  | epsilon                              | valid & ready
//
//  64-stage pipeline, one request per cycle while the output is not stalled.
//  Depth is set by the 48-stage restoring divider for the mass division.
//  Reset clears the stage valid bits and sets epsilon to 32'd1, one Q16.16 LSB.
//  A stalled output freezes the whole pipeline; in_if.ready follows.
module collision_velocity_resolver
  import cvr_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  cvr_in_if.sink  in_if,
  cvr_out_if.source out_if,
  cvr_cfg_if.sink cfg_if
);

  pipe_t            s_r   [NSTG];
  pipe_t            s_nxt [NSTG];
  logic [NSTG-1:0]  v_r;
  logic [31:0]      eps_r;
  logic             en;

  assign en           = !v_r[NSTG-1] || out_if.ready;
  assign in_if.ready  = en;
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= EPS_RST;
    end else if (cfg_if.valid) begin
      eps_r <= cfg_if.epsilon;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NSTG-2:0], in_if.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r <= s_nxt;
    end
  end

  always_comb begin
    pipe_t       c;
    logic [16:0] es;
    logic [16:0] et;
    logic [33:0] rt;
    logic        ge;
    logic [31:0] av;
    logic [31:0] ka;
    logic [31:0] kb;

    for (int k = 1; k < NSTG; k++) s_nxt[k] = s_r[k-1];

    // stage 0: capture
    c       = '0;
    c.vs[0] = in_if.src_vel_x;
    c.vs[1] = in_if.src_vel_y;
    c.vs[2] = in_if.src_vel_z;
    c.vt[0] = in_if.tgt_vel_x;
    c.vt[1] = in_if.tgt_vel_y;
    c.vt[2] = in_if.tgt_vel_z;
    c.n[0]  = in_if.normal_x;
    c.n[1]  = in_if.normal_y;
    c.n[2]  = in_if.normal_z;
    c.ms    = in_if.src_mass;
    c.mt    = in_if.tgt_mass;
    c.total = {1'b0, in_if.src_mass} + {1'b0, in_if.tgt_mass};
    es      = in_if.restitution_pair[16:0];
    et      = in_if.restitution_pair[33:17];
    c.cor   = (es < et) ? es : et;
    s_nxt[0] = c;

    // stage 1: flags, v_s.n products, relative velocity
    c = s_r[0];
    c.at_rest = (abs32(c.vt[0]) <= eps_r) && (abs32(c.vt[1]) <= eps_r) &&
                (abs32(c.vt[2]) <= eps_r);
    c.big    = c.total > {1'b0, eps_r};
    c.ms_big = c.ms > eps_r;
    c.mt_big = c.mt > eps_r;
    for (int i = 0; i < 3; i++) begin
      c.pr[i] = smul(c.vs[i], sx33(c.n[i]));
      c.dv[i] = sat32(sx(c.vs[i]) - sx(c.vt[i]));
    end
    s_nxt[1] = c;

    // stage 2
    c = s_r[1];
    c.d2 = dbl(dot3(c.pr));
    for (int i = 0; i < 3; i++) c.pm[i] = smul(c.dv[i], sx33(c.n[i]));
    s_nxt[2] = c;

    // stage 3
    c = s_r[2];
    for (int i = 0; i < 3; i++) c.pr[i] = smul(c.d2, sx33(c.n[i]));
    c.dm = dot3(c.pm);
    s_nxt[3] = c;

    // stage 4: reflected velocity
    c = s_r[3];
    for (int i = 0; i < 3; i++) c.r[i] = sat32(sx(c.vs[i]) - sx(mulq(c.pr[i])));
    c.sc = smul(c.dm, {16'd0, c.cor});
    s_nxt[4] = c;

    // stage 5
    c = s_r[4];
    for (int i = 0; i < 3; i++) begin
      c.pr[i] = smul(c.r[i], sx33(c.n[i]));
      c.pc[i] = smul(c.r[i], {16'd0, c.cor});
    end
    c.dmv = mulq(c.sc);
    s_nxt[5] = c;

    // stage 6
    c = s_r[5];
    c.dr = dot3(c.pr);
    for (int i = 0; i < 3; i++) c.so[i] = mulq(c.pc[i]);
    s_nxt[6] = c;

    // stage 7: impulse direction
    c = s_r[6];
    for (int i = 0; i < 3; i++) c.t[i] = ($signed(c.dr) > 0) ? nsat(c.n[i]) : c.n[i];
    c.dd2 = dbl(($signed(c.dr) > 0) ? c.dr : nsat(c.dr));
    s_nxt[7] = c;

    // stage 8
    c = s_r[7];
    c.sc = smul(c.dd2, {16'd0, c.cor});
    s_nxt[8] = c;

    // stage 9
    c = s_r[8];
    c.b = mulq(c.sc);
    s_nxt[9] = c;

    // divider load
    c = s_r[9];
    c.num = c.at_rest ? c.b : dbl(c.dmv);
    c.neg = c.num[31];
    av    = abs32(c.num);
    c.quo = {av, 16'd0};
    c.rem = '0;
    s_nxt[ST_DIV] = c;

    // restoring divider, one quotient bit per stage
    for (int k = ST_DIV + 1; k <= ST_DIV + DIV_W; k++) begin
      c  = s_r[k-1];
      rt = {c.rem, c.quo[DIV_W-1]};
      ge = rt >= {1'b0, c.total};
      c.rem = ge ? 33'(rt - {1'b0, c.total}) : rt[32:0];
      c.quo = {c.quo[DIV_W-2:0], ge};
      s_nxt[k] = c;
    end

    // signed, saturated quotient
    c = s_r[ST_J-1];
    c.j = c.neg ? sat32(-$signed({18'd0, c.quo})) : sat32($signed({18'd0, c.quo}));
    s_nxt[ST_J] = c;

    c = s_r[ST_J];
    c.pa = smul(c.j, {1'b0, c.ms});
    c.pb = smul(c.j, {1'b0, c.mt});
    s_nxt[ST_J+1] = c;

    // impulse scales
    c  = s_r[ST_J+1];
    ka = c.ms_big ? mulq(c.pa) : c.j;
    kb = c.mt_big ? mulq(c.pb) : c.j;
    c.kt = c.big ? ka : (c.at_rest ? c.b : c.dmv);
    c.ks = c.big ? kb : c.dmv;
    s_nxt[ST_J+2] = c;

    c = s_r[ST_J+2];
    for (int i = 0; i < 3; i++) begin
      c.pm[i] = smul(c.n[i], sx33(c.ks));
      c.pr[i] = smul(c.at_rest ? c.t[i] : c.n[i], sx33(c.kt));
    end
    s_nxt[ST_J+3] = c;

    // output register
    c = s_r[ST_J+3];
    for (int i = 0; i < 3; i++) begin
      if (!c.at_rest) begin
        c.so[i] = sat32(sx(c.vs[i]) - sx(mulq(c.pm[i])));
        c.t[i]  = sat32(sx(c.vt[i]) + sx(mulq(c.pr[i])));
      end else begin
        c.t[i]  = mulq(c.pr[i]);
      end
    end
    s_nxt[ST_J+4] = c;
  end

  assign out_if.valid     = v_r[NSTG-1];
  assign out_if.src_out_x = s_r[NSTG-1].so[0];
  assign out_if.src_out_y = s_r[NSTG-1].so[1];
  assign out_if.src_out_z = s_r[NSTG-1].so[2];
  assign out_if.tgt_out_x = s_r[NSTG-1].t[0];
  assign out_if.tgt_out_y = s_r[NSTG-1].t[1];
  assign out_if.tgt_out_z = s_r[NSTG-1].t[2];

endmodule

// ----- sv/cvr_chk.sv -----
// ----------------------------------------------------------------------------
// cvr_chk: port checker for the velocity resolver
// Handshake and flow checks seen from the top-level ports.
// ----------------------------------------------------------------------------
module cvr_chk (
  input logic         clk,
  input logic         rst_n,
  input logic         in_ready,
  input logic         out_valid,
  input logic         out_ready,
  input logic         cfg_ready,
  input logic [191:0] out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped under stall");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result changed under stall");

  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready not tied to output flow");

  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("epsilon write refused");

endmodule

bind collision_velocity_resolver cvr_chk u_cvr_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .cfg_ready (cfg_if.ready),
  .out_data  ({out_if.src_out_x, out_if.src_out_y, out_if.src_out_z,
               out_if.tgt_out_x, out_if.tgt_out_y, out_if.tgt_out_z})
);

// ----- dv/collision_velocity_resolver_test.sv -----
// ----------------------------------------------------------------------------
// collision_velocity_resolver_test: contact velocity resolver testbench
// Directed contacts at field extremes and both impulse branches, then random
// contacts under several epsilon settings and back-pressure mixes. Every
// resolved velocity pair is checked against an in-bench Q16.16 predictor.
// ----------------------------------------------------------------------------
module collision_velocity_resolver_test
  import cvr_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    vec_t        vs;
    vec_t        vt;
    vec_t        n;
    logic [31:0] ms;
    logic [31:0] mt;
    logic [33:0] rp;
  } contact_t;

  typedef struct packed {
    vec_t src;
    vec_t tgt;
  } vel_pair_t;

  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;
  localparam int     DRAIN_CYCLES = 100;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  cvr_in_if  in_ch();
  cvr_out_if out_ch();
  cvr_cfg_if cfg_ch();

  collision_velocity_resolver u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [31:0] epsilon_q = EPS_RST;
  vel_pair_t   pending_vels[$];
  int          snd_idle_pct = 0;
  int          rcv_stall_pct = 0;
  int          mismatches = 0;

  function automatic longint clamp(longint x);
    if (x > Q_MAX) return Q_MAX;
    if (x < Q_MIN) return Q_MIN;
    return x;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return clamp((a * b) >>> 16);
  endfunction

  function automatic longint qdiv(longint a, longint m);
    longint num;
    longint q;
    num = a * 65536;
    q = (num < 0 ? -num : num) / m;
    return clamp(num < 0 ? -q : q);
  endfunction

  function automatic longint qdot(longint a0, longint a1, longint a2,
                                  longint b0, longint b1, longint b2);
    return clamp(((a0 * b0) >>> 16) + ((a1 * b1) >>> 16) + ((a2 * b2) >>> 16));
  endfunction

  function automatic vel_pair_t resolve_contact(contact_t c);
    longint    vs[3], vt[3], n[3], r[3], t[3], so[3], to[3];
    longint    ms, mt, total, es, et, cor, eps, d, b, k, j, ks, kt;
    bit        rest;
    vel_pair_t res;
    ms = c.ms;
    mt = c.mt;
    total = ms + mt;
    es = c.rp[16:0];
    et = c.rp[33:17];
    cor = es < et ? es : et;
    eps = epsilon_q;
    rest = 1'b1;
    for (int i = 0; i < 3; i++) begin
      vs[i] = $signed(c.vs[i]);
      vt[i] = $signed(c.vt[i]);
      n[i] = $signed(c.n[i]);
      if ((vt[i] < 0 ? -vt[i] : vt[i]) > eps) rest = 1'b0;
    end
    if (rest) begin
      d = clamp(2 * qdot(vs[0], vs[1], vs[2], n[0], n[1], n[2]));
      for (int i = 0; i < 3; i++) r[i] = clamp(vs[i] - qmul(d, n[i]));
      d = qdot(r[0], r[1], r[2], n[0], n[1], n[2]);
      if (d > 0) begin
        for (int i = 0; i < 3; i++) t[i] = clamp(-n[i]);
      end else begin
        for (int i = 0; i < 3; i++) t[i] = n[i];
        d = clamp(-d);
      end
      b = qmul(clamp(2 * d), cor);
      if (total > eps) begin
        k = qdiv(b, total);
        if (ms > eps) k = qmul(k, ms);
      end else begin
        k = b;
      end
      for (int i = 0; i < 3; i++) begin
        so[i] = qmul(r[i], cor);
        to[i] = qmul(t[i], k);
      end
    end else begin
      for (int i = 0; i < 3; i++) r[i] = clamp(vs[i] - vt[i]);
      d = qmul(qdot(r[0], r[1], r[2], n[0], n[1], n[2]), cor);
      if (total > eps) begin
        j = qdiv(clamp(2 * d), total);
        ks = mt > eps ? qmul(j, mt) : j;
        kt = ms > eps ? qmul(j, ms) : j;
      end else begin
        ks = d;
        kt = d;
      end
      for (int i = 0; i < 3; i++) begin
        so[i] = clamp(vs[i] - qmul(n[i], ks));
        to[i] = clamp(vt[i] + qmul(n[i], kt));
      end
    end
    for (int i = 0; i < 3; i++) begin
      res.src[i] = so[i][31:0];
      res.tgt[i] = to[i][31:0];
    end
    return res;
  endfunction

  task automatic send_contact(contact_t c);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.src_vel_x <= c.vs[0];
    in_ch.src_vel_y <= c.vs[1];
    in_ch.src_vel_z <= c.vs[2];
    in_ch.tgt_vel_x <= c.vt[0];
    in_ch.tgt_vel_y <= c.vt[1];
    in_ch.tgt_vel_z <= c.vt[2];
    in_ch.normal_x <= c.n[0];
    in_ch.normal_y <= c.n[1];
    in_ch.normal_z <= c.n[2];
    in_ch.src_mass <= c.ms;
    in_ch.tgt_mass <= c.mt;
    in_ch.restitution_pair <= c.rp;
    do @(posedge clk); while (!in_ch.ready);
    pending_vels.push_back(resolve_contact(c));
  endtask

  task automatic drain;
    in_ch.valid <= 1'b0;
    while (pending_vels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_epsilon(logic [31:0] value);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.epsilon <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    epsilon_q = value;
  endtask

  function automatic logic [31:0] rand_vel();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(2 ** 24)) - (2 ** 23));
      default: return 32'($signed($urandom_range(2 ** 22)) - (2 ** 21));
    endcase
  endfunction

  function automatic contact_t rand_contact();
    contact_t c;
    int       lim;
    int       axis;
    lim = epsilon_q > 32'd4096 ? 4096 : int'(epsilon_q);
    axis = $urandom_range(2);
    for (int i = 0; i < 3; i++) begin
      c.vs[i] = rand_vel();
      c.vt[i] = $urandom_range(2) == 0 ? 32'($signed($urandom_range(2 * lim)) - lim)
                                         : rand_vel();
      case ($urandom_range(3))
        0: c.n[i] = $urandom();
        1: c.n[i] = 32'($signed($urandom_range(2 ** 17)) - (2 ** 16));
        default: c.n[i] = i == axis ? ($urandom_range(1) ? 32'h0001_0000 : 32'hFFFF_0000)
                                    : 32'd0;
      endcase
    end
    c.ms = $urandom_range(3) == 0 ? $urandom() : $urandom_range(32'h0010_0000);
    c.mt = $urandom_range(3) == 0 ? $urandom() : $urandom_range(32'h0010_0000);
    if ($urandom_range(9) == 0) c.ms = $urandom_range(2);
    if ($urandom_range(9) == 0) c.mt = $urandom_range(2);
    c.rp = $urandom_range(3) == 0 ? 34'({$urandom(), $urandom()}) :
           {17'($urandom_range(32'h1_0000)), 17'($urandom_range(32'h1_0000))};
    return c;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= $urandom_range(99) >= rcv_stall_pct;
    end
  end

  always @(posedge clk) begin
    vel_pair_t got;
    vel_pair_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.src = {out_ch.src_out_z, out_ch.src_out_y, out_ch.src_out_x};
      got.tgt = {out_ch.tgt_out_z, out_ch.tgt_out_y, out_ch.tgt_out_x};
      if (pending_vels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result src=%h tgt=%h", got.src, got.tgt);
      end else begin
        want = pending_vels.pop_front();
        for (int i = 0; i < 3; i++) begin
          if (got.src[i] !== want.src[i] || got.tgt[i] !== want.tgt[i]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("axis %0d: src exp %h got %h, tgt exp %h got %h", i,
                       want.src[i], got.src[i], want.tgt[i], got.tgt[i]);
          end
        end
      end
    end
  end

  function automatic contact_t make_contact(vec_t vs, vec_t vt, vec_t n,
                                            logic [31:0] ms, logic [31:0] mt,
                                            logic [33:0] rp);
    contact_t c;
    c.vs = vs;
    c.vt = vt;
    c.n = n;
    c.ms = ms;
    c.mt = mt;
    c.rp = rp;
    return c;
  endfunction

  task automatic test_directed;
    localparam logic [31:0] ONE = 32'h0001_0000;
    localparam logic [31:0] MONE = 32'hFFFF_0000;
    localparam logic [31:0] MAXV = 32'h7FFF_FFFF;
    localparam logic [31:0] MINV = 32'h8000_0000;
    localparam logic [33:0] E_HALF = {17'h0_8000, 17'h0_8000};
    // target at rest, head-on along x, reflected velocity points away
    send_contact(make_contact({32'd0, 32'd0, ONE * 3}, '0, {32'd0, 32'd0, ONE},
                              ONE, ONE, E_HALF));
    // reflected velocity with positive dot: impulse flips the normal
    send_contact(make_contact({32'd0, ONE, MONE}, '0, {32'd0, 32'd0, ONE},
                              ONE * 2, ONE, E_HALF));
    // target moving, ordinary masses
    send_contact(make_contact({32'd0, ONE, ONE * 2}, {32'd0, 32'd0, MONE},
                              {32'd0, 32'd0, ONE}, ONE, ONE * 4, E_HALF));
    // zero masses: division skipped
    send_contact(make_contact({32'd0, ONE, ONE}, {32'd0, 32'd0, MONE},
                              {32'd0, ONE, 32'd0}, 32'd0, 32'd0, E_HALF));
    send_contact(make_contact({ONE, ONE, ONE}, '0, {32'd0, ONE, 32'd0},
                              32'd0, 32'd1, E_HALF));
    // one mass tiny, other large
    send_contact(make_contact({ONE, ONE, ONE}, {ONE, 32'd0, 32'd0},
                              {ONE, 32'd0, 32'd0}, 32'd1, 32'hFFFF_FFFF, E_HALF));
    // restitution above one, and at its widest
    send_contact(make_contact({32'd0, 32'd0, ONE * 5}, {32'd0, 32'd0, ONE},
                              {32'd0, 32'd0, ONE}, ONE, ONE, {17'h1_FFFF, 17'h1_FFFF}));
    send_contact(make_contact({32'd0, 32'd0, ONE * 5}, '0, {32'd0, 32'd0, ONE},
                              ONE, ONE, {17'h1_FFFF, 17'h1_0000}));
    // zero restitution
    send_contact(make_contact({ONE, ONE, ONE}, {ONE, ONE, ONE}, {ONE, ONE, ONE},
                              ONE, ONE, 34'd0));
    // saturation at the extremes, non-unit normals
    send_contact(make_contact({MAXV, MINV, MAXV}, {MINV, MAXV, MINV},
                              {MAXV, MAXV, MINV}, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                              34'h3_FFFF_FFFF));
    send_contact(make_contact({MINV, MINV, MINV}, '0, {MINV, MINV, MINV},
                              32'hFFFF_FFFF, 32'd0, 34'h3_FFFF_FFFF));
    send_contact(make_contact({MAXV, MAXV, MAXV}, '0, {MAXV, MAXV, MAXV},
                              32'd5, 32'd5, {17'h1_0000, 17'h1_FFFF}));
    // target components right at and just past epsilon
    send_contact(make_contact({ONE, ONE, ONE}, {32'd1, 32'hFFFF_FFFF, 32'd1},
                              {ONE, 32'd0, 32'd0}, ONE, ONE, E_HALF));
    send_contact(make_contact({ONE, ONE, ONE}, {32'd2, 32'd0, 32'd0},
                              {ONE, 32'd0, 32'd0}, ONE, ONE, E_HALF));
    send_contact(make_contact('0, '0, '0, 32'd0, 32'd0, 34'd0));
    send_contact(make_contact({MONE, MONE, MONE}, {MINV, 32'd0, 32'd0},
                              {MONE, ONE, MONE}, 32'd2, 32'd0, E_HALF));
    drain();
  endtask

  task automatic test_random(int snd_pct, int rcv_pct, logic [31:0] eps_a,
                             logic [31:0] eps_b);
    snd_idle_pct = snd_pct;
    rcv_stall_pct = rcv_pct;
    write_epsilon(eps_a);
    repeat (250) send_contact(rand_contact());
    write_epsilon(eps_b);
    repeat (250) send_contact(rand_contact());
    drain();
  endtask

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.src_vel_x <= '0;
    in_ch.src_vel_y <= '0;
    in_ch.src_vel_z <= '0;
    in_ch.tgt_vel_x <= '0;
    in_ch.tgt_vel_y <= '0;
    in_ch.tgt_vel_z <= '0;
    in_ch.normal_x <= '0;
    in_ch.normal_y <= '0;
    in_ch.normal_z <= '0;
    in_ch.src_mass <= '0;
    in_ch.tgt_mass <= '0;
    in_ch.restitution_pair <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.epsilon <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(18, 83, 32'd0, 32'hFFFF_FFFF);
    test_random(83, 18, 32'h0001_0000, 32'd1);
    test_random(0, 0, 32'h0000_0100, 32'h8000_0000);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
